### rtl/ecvs_pkg.sv
// Shared types and constants for the enhanced clock victim selector.
package ecvs_pkg;

  // Default number of physical frames tracked.
  localparam int unsigned FRAME_COUNT_DEF = 64;

  // Width of the frame number fields on the ports.
  localparam int unsigned FRAME_W = 6;

  // Each stored entry holds {referenced, dirty}.
  localparam int unsigned ENTRY_W = 2;
  localparam int unsigned ENTRY_REF_BIT = 1;
  localparam int unsigned ENTRY_DIRTY_BIT = 0;

  // Operation codes carried by the opcode field.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;    // clearing pass: write one zero entry this cycle
    logic wr_item;   // a write transaction is accepted this cycle
    logic sel_start; // a select transaction is accepted this cycle
    logic scan_en;   // the scan evaluates one frame this cycle
  } ecvs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the clearing pass writes its last entry this cycle
    logic scan_done; // the scan settles on a victim this cycle
  } ecvs_sts_t;

endpackage

### rtl/ecvs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ecvs_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ecvs_datapath.sv
// Datapath: frame status RAM, clock hand, scan registers and result register.
module ecvs_datapath #(
  parameter int unsigned FRAME_COUNT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ecvs_pkg::ecvs_cmd_t           cmd_i,
  output ecvs_pkg::ecvs_sts_t           sts_o,
  input  logic [ecvs_pkg::FRAME_W-1:0]  frame_index_i,
  input  logic                          referenced_in_i,
  input  logic                          dirty_in_i,
  output logic [ecvs_pkg::FRAME_W-1:0]  evict_frame_o,
  output logic                          victim_valid_o
);
  import ecvs_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_COUNT);
  localparam int unsigned CW = ((AW > FRAME_W) ? AW : FRAME_W) + 1;
  localparam logic [AW-1:0] LAST_FRAME = AW'(FRAME_COUNT - 1);
  localparam logic [CW-1:0] FRAME_LIMIT = CW'(FRAME_COUNT);

  logic [AW-1:0] hand_q, hand_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          lap_q, lap_d;
  logic          have_ud_q, have_ud_d, have_rc_q, have_rc_d, have_rd_q, have_rd_d;
  logic [AW-1:0] first_ud_q, first_ud_d, first_rc_q, first_rc_d, first_rd_q, first_rd_d;
  logic [FRAME_W-1:0] evict_frame_q, evict_frame_d;
  logic               victim_valid_q, victim_valid_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic          cur_ref, cur_dirty, pick_now, wrap;
  logic [AW-1:0] nxt;
  logic          ud_eff, rc_eff, rd_eff;
  logic [AW-1:0] ud_idx, rc_idx, rd_idx, victim_idx;
  logic [CW-1:0] frame_ext, victim_ext;
  logic          in_range;

  ecvs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAME_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur_ref   = ram_rdata[ENTRY_REF_BIT];
  assign cur_dirty = ram_rdata[ENTRY_DIRTY_BIT];
  assign pick_now  = !cur_ref && !cur_dirty;
  assign nxt       = (cur_q == LAST_FRAME) ? '0 : cur_q + AW'(1);
  assign wrap      = (nxt == '0);

  // Class records including the frame seen in this cycle.
  assign ud_eff = have_ud_q || (!cur_ref && cur_dirty);
  assign rc_eff = have_rc_q || (cur_ref && !cur_dirty);
  assign rd_eff = have_rd_q || (cur_ref && cur_dirty);
  assign ud_idx = have_ud_q ? first_ud_q : cur_q;
  assign rc_idx = have_rc_q ? first_rc_q : cur_q;
  assign rd_idx = have_rd_q ? first_rd_q : cur_q;

  always_comb begin
    if (pick_now) begin
      victim_idx = cur_q;
    end else if (ud_eff) begin
      victim_idx = ud_idx;
    end else if (rc_eff) begin
      victim_idx = rc_idx;
    end else if (rd_eff) begin
      victim_idx = rd_idx;
    end else begin
      victim_idx = '0;
    end
  end

  assign frame_ext  = CW'(frame_index_i);
  assign in_range   = frame_ext < FRAME_LIMIT;
  assign victim_ext = CW'(victim_idx);

  assign sts_o.clr_last  = (clr_q == LAST_FRAME);
  assign sts_o.scan_done = pick_now || (wrap && lap_q);

  // RAM ports. Reads run one frame ahead of the evaluation.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '0;
    if (cmd_i.clr_en) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
    end else if (cmd_i.wr_item) begin
      ram_we    = in_range;
      ram_waddr = frame_ext[AW-1:0];
      ram_wdata = {referenced_in_i, dirty_in_i};
    end else if (cmd_i.scan_en && !pick_now) begin
      ram_we    = 1'b1;
      ram_waddr = cur_q;
      ram_wdata = {1'b0, cur_dirty};
    end
    ram_raddr = cmd_i.sel_start ? hand_q : nxt;
  end

  always_comb begin
    hand_d         = hand_q;
    cur_d          = cur_q;
    clr_d          = clr_q;
    lap_d          = lap_q;
    have_ud_d      = have_ud_q;
    have_rc_d      = have_rc_q;
    have_rd_d      = have_rd_q;
    first_ud_d     = first_ud_q;
    first_rc_d     = first_rc_q;
    first_rd_d     = first_rd_q;
    evict_frame_d  = evict_frame_q;
    victim_valid_d = victim_valid_q;
    if (cmd_i.clr_en) begin
      clr_d = clr_q + AW'(1);
    end
    if (cmd_i.wr_item) begin
      evict_frame_d  = '0;
      victim_valid_d = 1'b0;
    end
    if (cmd_i.sel_start) begin
      cur_d     = hand_q;
      lap_d     = 1'b0;
      have_ud_d = 1'b0;
      have_rc_d = 1'b0;
      have_rd_d = 1'b0;
    end
    if (cmd_i.scan_en) begin
      if (pick_now) begin
        hand_d = cur_q;
      end else begin
        hand_d     = nxt;
        cur_d      = nxt;
        lap_d      = lap_q || wrap;
        have_ud_d  = ud_eff;
        have_rc_d  = rc_eff;
        have_rd_d  = rd_eff;
        first_ud_d = ud_idx;
        first_rc_d = rc_idx;
        first_rd_d = rd_idx;
      end
      if (sts_o.scan_done) begin
        evict_frame_d  = victim_ext[FRAME_W-1:0];
        victim_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hand_q    <= '0;
      clr_q     <= '0;
      lap_q     <= 1'b0;
      have_ud_q <= 1'b0;
      have_rc_q <= 1'b0;
      have_rd_q <= 1'b0;
    end else begin
      hand_q    <= hand_d;
      clr_q     <= clr_d;
      lap_q     <= lap_d;
      have_ud_q <= have_ud_d;
      have_rc_q <= have_rc_d;
      have_rd_q <= have_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q          <= cur_d;
    first_ud_q     <= first_ud_d;
    first_rc_q     <= first_rc_d;
    first_rd_q     <= first_rd_d;
    evict_frame_q  <= evict_frame_d;
    victim_valid_q <= victim_valid_d;
  end

  assign evict_frame_o  = evict_frame_q;
  assign victim_valid_o = victim_valid_q;

endmodule

### rtl/ecvs_ctrl.sv
// Controller: clearing pass, idle and scan sequencing, and the handshakes.
module ecvs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ecvs_pkg::ecvs_cmd_t cmd_o,
  input  ecvs_pkg::ecvs_sts_t sts_i
);
  import ecvs_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, scan_finish;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign scan_finish = (state_q == ST_SCAN) && sts_i.scan_done;

  assign cmd_o.clr_en    = (state_q == ST_CLEAR);
  assign cmd_o.wr_item   = accept && (opcode_i == OP_WRITE);
  assign cmd_o.sel_start = accept && (opcode_i == OP_SELECT);
  assign cmd_o.scan_en   = (state_q == ST_SCAN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_o.sel_start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.wr_item || scan_finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/enhanced_clock_victim_select.sv
// Timing: a write transaction yields its result in the cycle after acceptance; a select
// evaluates one frame per cycle, paced by the status RAM read port.
// Transactions go one at a time: a write every cycle while results are taken, none during a scan.
// Reset: the hand goes to frame 0 and a clearing pass zeroes every frame's referenced and
// dirty bits; in_ready_o stays low until that pass is finished.
module enhanced_clock_victim_select #(
  parameter int unsigned FRAME_COUNT = ecvs_pkg::FRAME_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [ecvs_pkg::FRAME_W-1:0] frame_index_i,
  input  logic                         referenced_in_i,
  input  logic                         dirty_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ecvs_pkg::FRAME_W-1:0] evict_frame_o,
  output logic                         victim_valid_o
);
  import ecvs_pkg::*;

  // The controller owns the state machine and both handshakes. The datapath
  // keeps the per-frame status bits in a RAM, the clock hand, the first frame
  // seen of each class during a scan, and the registered result.
  ecvs_cmd_t cmd;
  ecvs_sts_t sts;

  ecvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // During a scan the RAM read for the next frame is issued in the same cycle
  // that the current frame is evaluated and its referenced bit cleared, so
  // the hand moves one frame per cycle. A scan ends either on the first
  // unreferenced clean frame or when the hand wraps to zero for the second
  // time, where the recorded class candidates are ranked.
  ecvs_datapath #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .frame_index_i   (frame_index_i),
    .referenced_in_i (referenced_in_i),
    .dirty_in_i      (dirty_in_i),
    .evict_frame_o   (evict_frame_o),
    .victim_valid_o  (victim_valid_o)
  );

`ifndef SYNTH
  // A select transaction occupies the block until its scan completes.
  a_select_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_SELECT) |=> !in_ready_o)
    else $error("input accepted right after a select transaction");

  // A write transaction produces its result in the following cycle.
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_WRITE) |=> (out_valid_o && !victim_valid_o))
    else $error("write transaction did not produce a write result");

  // Results of write transactions always carry frame zero.
  a_write_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !victim_valid_o) |-> (evict_frame_o == '0))
    else $error("write result carries a nonzero frame");
`endif

endmodule

### verif/ecvs_victim_checker.sv
// Checker for the clock victim selector: predicts every transaction's result and compares.
module ecvs_victim_checker
  import ecvs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               opcode_i,
  input  logic [FRAME_W-1:0] frame_index_i,
  input  logic               referenced_i,
  input  logic               dirty_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [FRAME_W-1:0] evict_frame_i,
  input  logic               victim_valid_i,
  output int                 error_count_o,
  output int                 pending_o,
  output int                 results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAMES = FRAME_COUNT_DEF;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               valid;
  } victim_t;

  int unsigned hand;
  logic        ref_bits   [FRAMES];
  logic        dirty_bits [FRAMES];
  victim_t     expected_victims[$];

  // Second-chance sweep from the hand. Frames passed over lose their referenced bit;
  // after the hand wraps to zero twice the best class seen first wins.
  function automatic logic [FRAME_W-1:0] pick_victim();
    int unsigned pos, wraps, first_ud, first_rc, first_rd;
    bit seen_ud, seen_rc, seen_rd;
    logic r, d;
    pos = hand;
    wraps = 0;
    seen_ud = 1'b0;
    seen_rc = 1'b0;
    seen_rd = 1'b0;
    first_ud = 0;
    first_rc = 0;
    first_rd = 0;
    while (1) begin
      r = ref_bits[pos];
      d = dirty_bits[pos];
      if (!r && !d) begin
        hand = pos;
        return FRAME_W'(pos);
      end
      if (!r && d && !seen_ud) begin
        seen_ud = 1'b1;
        first_ud = pos;
      end
      if (r && !d && !seen_rc) begin
        seen_rc = 1'b1;
        first_rc = pos;
      end
      if (r && d && !seen_rd) begin
        seen_rd = 1'b1;
        first_rd = pos;
      end
      ref_bits[pos] = 1'b0;
      pos = (pos + 1 >= FRAMES) ? 0 : pos + 1;
      hand = pos;
      if (pos == 0) begin
        wraps++;
        if (wraps >= 2) begin
          if (seen_ud) return FRAME_W'(first_ud);
          if (seen_rc) return FRAME_W'(first_rc);
          if (seen_rd) return FRAME_W'(first_rd);
          return '0;
        end
      end
    end
  endfunction

  function automatic victim_t apply_item(input logic op, input logic [FRAME_W-1:0] idx,
                                         input logic r, input logic d);
    victim_t res;
    res = '0;
    if (op == OP_WRITE) begin
      if (idx < FRAMES) begin
        ref_bits[idx] = r;
        dirty_bits[idx] = d;
      end
    end else begin
      res.frame = pick_victim();
      res.valid = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    victim_t want;
    if (!rst_ni) begin
      hand = 0;
      foreach (ref_bits[i]) begin
        ref_bits[i] = 1'b0;
        dirty_bits[i] = 1'b0;
      end
      expected_victims.delete();
      error_count_o = 0;
      results_o = 0;
      pending_o = 0;
    end else begin
      // A result never answers a transaction accepted at the same edge, so check it first.
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_victims.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected result evict_frame=%0d victim_valid=%0b",
                   $time, evict_frame_i, victim_valid_i);
        end else begin
          want = expected_victims.pop_front();
          if (evict_frame_i !== want.frame) begin
            error_count_o++;
            $display("%0t: evict_frame expected %0d actual %0d",
                     $time, want.frame, evict_frame_i);
          end
          if (victim_valid_i !== want.valid) begin
            error_count_o++;
            $display("%0t: victim_valid expected %0b actual %0b",
                     $time, want.valid, victim_valid_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_victims.push_back(apply_item(opcode_i, frame_index_i, referenced_i, dirty_i));
      end
      pending_o = expected_victims.size();
    end
  end

endmodule

### verif/enhanced_clock_victim_select_test.sv
// Top-level testbench for the clock victim selector: stimulus, idling and the verdict.
module enhanced_clock_victim_select_test;
  import ecvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAMES = FRAME_COUNT_DEF;
  // Random part stops once this many transactions have been sent in it.
  localparam int RANDOM_ITEMS = 900;
  // The slowest correct run is near 1000 transactions, each select sweeping at most twice round,
  // plus sender gaps and receiver stalls; this bound leaves several times that margin.
  localparam int CYCLE_LIMIT = 600_000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               opcode_i;
  logic [FRAME_W-1:0] frame_index_i;
  logic               referenced_in_i;
  logic               dirty_in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [FRAME_W-1:0] evict_frame_o;
  logic               victim_valid_o;

  int error_count;
  int pending;
  int results;

  // Idle rates in percent; they change with the phase of the run.
  int send_idle_pct;
  int recv_idle_pct;
  int sent_count;
  int select_count;
  int cycle_count;

  enhanced_clock_victim_select #(.FRAME_COUNT(FRAMES)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .frame_index_i   (frame_index_i),
    .referenced_in_i (referenced_in_i),
    .dirty_in_i      (dirty_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .evict_frame_o   (evict_frame_o),
    .victim_valid_o  (victim_valid_o)
  );

  ecvs_victim_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .opcode_i       (opcode_i),
    .frame_index_i  (frame_index_i),
    .referenced_i   (referenced_in_i),
    .dirty_i        (dirty_in_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .evict_frame_i  (evict_frame_o),
    .victim_valid_i (victim_valid_o),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .results_o      (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a runaway scan ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("status: fail");
    $finish;
  end

  // The receiver decides its ready level once per cycle, at the falling edge.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Presents one transaction and holds it until the block takes it. The idle phase is
  // chosen from how many transactions have gone out: first the receiver stalls a lot,
  // then the sender, then neither side idles at all.
  task automatic send_item(input logic op, input logic [FRAME_W-1:0] idx,
                           input logic r, input logic d);
    if (sent_count < 330) begin
      send_idle_pct = 7;
      recv_idle_pct = 71;
    end else if (sent_count < 660) begin
      send_idle_pct = 71;
      recv_idle_pct = 7;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    frame_index_i = idx;
    referenced_in_i = r;
    dirty_in_i = d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    if (op == OP_SELECT) select_count++;
    @(negedge clk_i);
  endtask

  // A select whose write-only fields carry random junk, which the block must ignore.
  task automatic send_select();
    send_item(OP_SELECT, FRAME_W'($urandom_range(0, FRAMES - 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int random_sent;
    int kind;
    int start;
    int run_len;
    int ref_pct;
    int dirty_pct;
    int burst;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_WRITE;
    frame_index_i = '0;
    referenced_in_i = 1'b0;
    dirty_in_i = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 71;
    sent_count = 0;
    select_count = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Right after reset every frame is clean and unreferenced, so the
    // first select takes frame 0 with all-ones junk on the ignored fields.
    send_item(OP_SELECT, '1, 1'b1, 1'b1);
    // One frame of each class in front of a clean frame 3: the sweep passes frames
    // 0 to 2, clears their referenced bits and settles on frame 3.
    send_item(OP_WRITE, 6'd0, 1'b1, 1'b1);
    send_item(OP_WRITE, 6'd1, 1'b0, 1'b1);
    send_item(OP_WRITE, 6'd2, 1'b1, 1'b0);
    send_item(OP_WRITE, '1, 1'b1, 1'b0);
    send_select();
    // The hand stays on the frame it took; dirty that frame and clean the next one.
    send_item(OP_WRITE, 6'd3, 1'b1, 1'b1);
    send_item(OP_WRITE, 6'd4, 1'b0, 1'b0);
    send_select();
    send_select();
    // Top frames 62 and 63 in the dirty classes, frame 4 referenced, and all-zero writes back to clean.
    send_item(OP_WRITE, '1, 1'b0, 1'b1);
    send_item(OP_WRITE, 6'd62, 1'b1, 1'b1);
    send_item(OP_WRITE, 6'd4, 1'b1, 1'b0);
    send_select();
    send_item(OP_WRITE, 6'd0, 1'b0, 1'b0);
    send_item(OP_WRITE, 6'd42, 1'b0, 1'b0);
    send_select();
    send_item(OP_SELECT, '0, 1'b0, 1'b0);

    // Random part. Most of it fills a run of frames with mostly dirty or referenced
    // bits and then selects, so that sweeps go around the clock once or twice and the
    // second-wrap class ranking gets exercised; the rest is bursts of random transactions
    // and back-to-back selects.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        start = $urandom_range(0, FRAMES - 1);
        run_len = ($urandom_range(0, 3) == 0) ? FRAMES : $urandom_range(8, FRAMES);
        case ($urandom_range(0, 2))
          0: dirty_pct = 50;
          1: dirty_pct = 90;
          default: dirty_pct = 100;
        endcase
        ref_pct = $urandom_range(0, 100);
        for (int i = 0; i < run_len; i++) begin
          send_item(OP_WRITE, FRAME_W'((start + i) % FRAMES),
                    1'($urandom_range(0, 99) < ref_pct),
                    1'($urandom_range(0, 99) < dirty_pct));
        end
        burst = $urandom_range(1, 4);
        for (int i = 0; i < burst; i++) send_select();
        random_sent += run_len + burst;
      end else if (kind <= 7) begin
        burst = $urandom_range(1, 8);
        for (int i = 0; i < burst; i++) begin
          send_item(1'($urandom_range(0, 1)), FRAME_W'($urandom_range(0, FRAMES - 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        random_sent += burst;
      end else begin
        burst = $urandom_range(1, 3);
        for (int i = 0; i < burst; i++) send_select();
        random_sent += burst;
      end
    end
    in_valid_i = 1'b0;

    // Drain: wait for every expected result, then give a stray result the time of
    // one longest sweep to show up.
    while (pending != 0) @(negedge clk_i);
    repeat (2 * FRAMES + 4) @(negedge clk_i);

    $display("sent %0d transactions (%0d selects, %0d writes) and checked %0d results",
             sent_count, select_count, sent_count - select_count, results);
    $display("idle phases: receiver-heavy stalls, sender-heavy gaps, then none; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
